// ===== hw/rtl/roman_numeral_encoder_core_macros.svh =====
// Assertion macros used by the back end of the Roman numeral encoder.
`ifndef ROMAN_NUMERAL_ENCODER_CORE_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_CORE_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define RNE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define RNE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rne_pkg.sv =====
// Package with types, constants and digit tables of the Roman numeral encoder.
`default_nettype none

package rne_pkg;

   localparam int NUMBER_W   = 12;
   localparam int SYMBOL_W   = 7;
   localparam int DIGITS     = 4;
   localparam int PLACE_W    = $clog2(DIGITS);
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [NUMBER_W-1:0] MAX_NUMBER = NUMBER_W'(3999);

   localparam logic [PLACE_W-1:0] PLACE_THOU = PLACE_W'(0);
   localparam logic [PLACE_W-1:0] PLACE_HUN  = PLACE_W'(1);
   localparam logic [PLACE_W-1:0] PLACE_TEN  = PLACE_W'(2);
   localparam logic [PLACE_W-1:0] PLACE_UNIT = PLACE_W'(3);

   localparam logic [SYMBOL_W-1:0] SYM_NONE = SYMBOL_W'(0);
   localparam logic [SYMBOL_W-1:0] SYM_I    = SYMBOL_W'(73);
   localparam logic [SYMBOL_W-1:0] SYM_V    = SYMBOL_W'(86);
   localparam logic [SYMBOL_W-1:0] SYM_X    = SYMBOL_W'(88);
   localparam logic [SYMBOL_W-1:0] SYM_L    = SYMBOL_W'(76);
   localparam logic [SYMBOL_W-1:0] SYM_C    = SYMBOL_W'(67);
   localparam logic [SYMBOL_W-1:0] SYM_D    = SYMBOL_W'(68);
   localparam logic [SYMBOL_W-1:0] SYM_M    = SYMBOL_W'(77);

   typedef enum logic [1:0] {
      RANK_ONE,
      RANK_FIVE,
      RANK_TEN
   } rank_type;

   // One converted number as it waits between front and back.
   typedef struct packed {
      logic       err;
      logic [1:0] thou;
      logic [3:0] hun;
      logic [3:0] ten;
      logic [3:0] unit;
   } rne_entry_type;

   // Number of characters that one decimal digit produces.
   function automatic logic [2:0] digit_len(input logic [3:0] d);
      logic [2:0] len;
      case (d)
         4'd0:    len = 3'd0;
         4'd1:    len = 3'd1;
         4'd2:    len = 3'd2;
         4'd3:    len = 3'd3;
         4'd4:    len = 3'd2;
         4'd5:    len = 3'd1;
         4'd6:    len = 3'd2;
         4'd7:    len = 3'd3;
         4'd8:    len = 3'd4;
         4'd9:    len = 3'd2;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // Which of the one, five and ten symbols stands at a position of a digit.
   function automatic rank_type digit_rank(input logic [3:0] d, input logic [1:0] i);
      rank_type r;
      case (d)
         4'd4:                   r = (i == 2'd1) ? RANK_FIVE : RANK_ONE;
         4'd5, 4'd6, 4'd7, 4'd8: r = (i == 2'd0) ? RANK_FIVE : RANK_ONE;
         4'd9:                   r = (i == 2'd1) ? RANK_TEN  : RANK_ONE;
         default:                r = RANK_ONE;
      endcase
      return r;
   endfunction

   function automatic logic [SYMBOL_W-1:0] place_symbol(input logic [PLACE_W-1:0] p,
                                                       input rank_type r);
      logic [SYMBOL_W-1:0] s;
      case (p)
         PLACE_THOU: s = SYM_M;
         PLACE_HUN: begin
            case (r)
               RANK_ONE:  s = SYM_C;
               RANK_FIVE: s = SYM_D;
               default:   s = SYM_M;
            endcase
         end
         PLACE_TEN: begin
            case (r)
               RANK_ONE:  s = SYM_X;
               RANK_FIVE: s = SYM_L;
               default:   s = SYM_C;
            endcase
         end
         default: begin
            case (r)
               RANK_ONE:  s = SYM_I;
               RANK_FIVE: s = SYM_V;
               default:   s = SYM_X;
            endcase
         end
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rne_if.sv =====
// Handshake interfaces of the request and response channels.
`default_nettype none

interface rne_req_if import rne_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [NUMBER_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface rne_rsp_if import rne_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                last_symbol;
   logic                out_of_range;

   modport source (output valid, output symbol, output last_symbol, output out_of_range,
                   input ready);
   modport sink   (input valid, input symbol, input last_symbol, input out_of_range,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rne_front.sv =====
// Front end: accepts numbers, checks the range and splits them into decimal digits.
`default_nettype none

module rne_front import rne_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   rne_req_if.sink            req,
   output logic               out_valid,
   input  wire logic          out_ready,
   output rne_entry_type      out_entry
);

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_err_ff;
   logic [1:0]       s1_thou_ff;
   logic [9:0]       s1_rem_ff;
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_err_ff;
   logic [1:0]       s2_thou_ff;
   logic [3:0]       s2_hun_ff;
   logic [6:0]       s2_rem_ff;

   logic             s1_ready, s2_ready;
   logic             s1_load, s2_load;
   logic             err_c;
   logic [1:0]       thou_c;
   logic [NUMBER_W-1:0] thou_sub_c;
   logic [3:0]       hun_c;
   logic [9:0]       hun_sub_c;
   logic [3:0]       ten_c;
   logic [6:0]       ten_sub_c;
   logic [3:0]       unit_c;

   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;
   assign s1_load   = req.valid && s1_ready;
   assign s2_load   = s1_valid_ff && s2_ready;

   // Stage one: range check and thousands digit.
   always_comb begin
      err_c = (req.number == '0) || (req.number > MAX_NUMBER);
      if (req.number >= NUMBER_W'(3000)) begin
         thou_c     = 2'd3;
         thou_sub_c = NUMBER_W'(3000);
      end else if (req.number >= NUMBER_W'(2000)) begin
         thou_c     = 2'd2;
         thou_sub_c = NUMBER_W'(2000);
      end else if (req.number >= NUMBER_W'(1000)) begin
         thou_c     = 2'd1;
         thou_sub_c = NUMBER_W'(1000);
      end else begin
         thou_c     = 2'd0;
         thou_sub_c = '0;
      end
   end

   // Stage two: hundreds digit by parallel compares against the multiples of 100.
   always_comb begin
      hun_c     = 4'd0;
      hun_sub_c = 10'd0;
      for (int k = 1; k < 10; k++) begin
         if (s1_rem_ff >= 10'(k * 100)) begin
            hun_c     = 4'(k);
            hun_sub_c = 10'(k * 100);
         end
      end
   end

   // Tens and units are split on the way into the queue.
   always_comb begin
      ten_c     = 4'd0;
      ten_sub_c = 7'd0;
      for (int k = 1; k < 10; k++) begin
         if (s2_rem_ff >= 7'(k * 10)) begin
            ten_c     = 4'(k);
            ten_sub_c = 7'(k * 10);
         end
      end
      unit_c = 4'(s2_rem_ff - ten_sub_c);
   end

   always_comb begin
      s1_valid_in = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
      s2_valid_in = s2_load ? 1'b1 : (out_ready ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_load) begin
         s1_err_ff  <= err_c;
         s1_thou_ff <= thou_c;
         s1_rem_ff  <= 10'(req.number - thou_sub_c);
      end
      if (s2_load) begin
         s2_err_ff  <= s1_err_ff;
         s2_thou_ff <= s1_thou_ff;
         s2_hun_ff  <= hun_c;
         s2_rem_ff  <= 7'(s1_rem_ff - hun_sub_c);
      end
   end

   assign out_valid      = s2_valid_ff;
   assign out_entry.err  = s2_err_ff;
   assign out_entry.thou = s2_thou_ff;
   assign out_entry.hun  = s2_hun_ff;
   assign out_entry.ten  = ten_c;
   assign out_entry.unit = unit_c;

endmodule

`default_nettype wire

// ===== hw/rtl/rne_fifo.sv =====
// Short queue of digit entries between the front end and the symbol sequencer.
`default_nettype none

module rne_fifo import rne_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_valid,
   output logic               wr_ready,
   input  wire rne_entry_type wr_data,
   output logic               rd_valid,
   input  wire logic          rd_ready,
   output rne_entry_type      rd_data
);

   rne_entry_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  push, pop;

   assign wr_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rne_back.sv =====
// Back end: walks the digits of one entry and emits one numeral character per word.
`default_nettype none
`include "roman_numeral_encoder_core_macros.svh"

module rne_back import rne_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire rne_entry_type in_entry,
   rne_rsp_if.source          rsp
);

   logic                work_valid_ff, work_valid_in;
   logic                err_ff;
   logic [3:0]          dig_ff [DIGITS];
   logic [DIGITS-1:0]   mask_ff, mask_in;
   logic [1:0]          idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] symbol_ff;
   logic                last_ff;
   logic                oor_ff;

   logic                out_free, emit, load, digit_done, is_last;
   logic [PLACE_W-1:0]  place;
   logic [3:0]          cur_digit;
   logic [2:0]          cur_len;
   logic [DIGITS-1:0]   mask_clr;
   logic [DIGITS-1:0]   load_mask;
   logic [SYMBOL_W-1:0] cur_symbol;

   // The lowest set bit of the mask is the highest remaining decimal place.
   always_comb begin
      place = PLACE_W'(DIGITS - 1);
      for (int k = DIGITS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            place = PLACE_W'(k);
         end
      end
   end

   always_comb begin
      cur_digit  = dig_ff[place];
      cur_len    = digit_len(cur_digit);
      cur_symbol = place_symbol(place, digit_rank(cur_digit, idx_ff));
      digit_done = ({1'b0, idx_ff} + 3'd1) >= cur_len;
      mask_clr   = mask_ff;
      mask_clr[place] = 1'b0;
      is_last    = err_ff || (digit_done && (mask_clr == '0));
      out_free   = !rsp_valid_ff || rsp.ready;
      emit       = work_valid_ff && out_free;
      load       = !work_valid_ff || (emit && is_last);
      in_ready   = load;
      load_mask  = in_entry.err ? '0 : {in_entry.unit != 4'd0, in_entry.ten != 4'd0,
                                        in_entry.hun != 4'd0, in_entry.thou != 2'd0};
   end

   always_comb begin
      work_valid_in = work_valid_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      if (load && in_valid) begin
         work_valid_in = 1'b1;
         mask_in       = load_mask;
         idx_in        = 2'd0;
      end else if (emit && is_last) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         mask_in = digit_done ? mask_clr : mask_ff;
         idx_in  = digit_done ? 2'd0 : idx_ff + 2'd1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mask_ff <= mask_in;
      idx_ff  <= idx_in;
      if (load && in_valid) begin
         err_ff         <= in_entry.err;
         dig_ff[PLACE_THOU] <= {2'b00, in_entry.thou};
         dig_ff[PLACE_HUN]  <= in_entry.hun;
         dig_ff[PLACE_TEN]  <= in_entry.ten;
         dig_ff[PLACE_UNIT] <= in_entry.unit;
      end
      if (emit) begin
         symbol_ff <= err_ff ? SYM_NONE : cur_symbol;
         last_ff   <= is_last;
         oor_ff    <= err_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.symbol       = symbol_ff;
   assign rsp.last_symbol  = last_ff;
   assign rsp.out_of_range = oor_ff;

   `RNE_ASSERT_IMP(a_err_word_form, clock, reset, rsp_valid_ff && oor_ff,
      last_ff && (symbol_ff == SYM_NONE), "error word must be a single last zero character")
   `RNE_ASSERT_IMP(a_good_word_symbol, clock, reset, rsp_valid_ff && !oor_ff,
      symbol_ff != SYM_NONE, "numeral word carries no character")
   `RNE_ASSERT_IMP(a_work_has_digit, clock, reset, work_valid_ff && !err_ff,
      (mask_ff != '0) && ({1'b0, idx_ff} < cur_len), "sequencer points past its digits")
   `RNE_ASSERT_NXT(a_last_frees_slot, clock, reset, emit && is_last && !in_valid,
      !work_valid_ff, "sequencer stays busy after the last character")

endmodule

`default_nettype wire

// ===== hw/rtl/roman_numeral_encoder_core.sv =====
// Top level of the Roman numeral encoder: front end, digit queue and symbol sequencer.
//
//   channel  direction  handshake          payload
//   req      in         req.valid/ready    number[11:0]
//   rsp      out        rsp.valid/ready    symbol[6:0], last_symbol, out_of_range
//
// A number passes two front stages, waits in a two-entry queue and is then read out
// by the sequencer at one character per cycle while rsp is ready; a numeral has 1 to 15
// characters, and an out-of-range number gives a single error word.
// Before its first word a number is registered in both front stages, the queue, the sequencer and the output register.
// Reset is synchronous and clears all handshake state; no clearing pass is needed.
// A stall on rsp fills the output register, holds the sequencer, then fills the queue, then the front stages.
`default_nettype none

module roman_numeral_encoder_core import rne_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   rne_req_if.sink   req,
   rne_rsp_if.source rsp
);

   logic          front_valid, front_ready;
   rne_entry_type front_entry;
   logic          queue_valid, queue_ready;
   rne_entry_type queue_entry;

   rne_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_entry (front_entry)
   );

   rne_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_data  (front_entry),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_data  (queue_entry)
   );

   rne_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_valid),
      .in_ready (queue_ready),
      .in_entry (queue_entry),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

// ===== tb/roman_numeral_encoder_core_tb.sv =====
// Self-checking testbench of the Roman numeral encoder core with random handshakes.
module roman_numeral_encoder_core_tb import rne_pkg::*; ();

   localparam int TIMEOUT_CYCLES = 200000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int IDLE_PERCENT   = 24;
   localparam int QUIET_FIRST    = 1500;
   localparam int QUIET_LAST     = 2700;
   localparam int HOLD_AFTER     = 150;
   localparam int HOLD_CYCLES    = 250;
   localparam int RANDOM_ITEMS   = 336;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last_symbol;
      logic                out_of_range;
   } numeral_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rne_req_if req_bus ();
   rne_rsp_if rsp_bus ();

   roman_numeral_encoder_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   logic [NUMBER_W-1:0] pending_numbers[$];
   numeral_word_type    expected_symbols[$];

   int  cycle_count     = 0;
   int  error_count     = 0;
   int  numbers_sent    = 0;
   int  numbers_valid   = 0;
   int  numbers_invalid = 0;
   int  symbols_checked = 0;
   int  longest_numeral = 0;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   bit  quiet;

   always #5 clock = ~clock;

   initial begin
      req_bus.valid  = 1'b0;
      req_bus.number = '0;
      rsp_bus.ready  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Character for a decimal place (thousands first) and a rank: 0 one, 1 five, 2 ten.
   function automatic logic [SYMBOL_W-1:0] place_glyph(input int place, input int rank);
      logic [SYMBOL_W-1:0] g;
      case (place)
         0:       g = SYM_M;
         1:       g = (rank == 0) ? SYM_C : (rank == 1) ? SYM_D : SYM_M;
         2:       g = (rank == 0) ? SYM_X : (rank == 1) ? SYM_L : SYM_C;
         default: g = (rank == 0) ? SYM_I : (rank == 1) ? SYM_V : SYM_X;
      endcase
      return g;
   endfunction

   task automatic predict_numeral(input logic [NUMBER_W-1:0] value);
      logic [SYMBOL_W-1:0] chars[$];
      numeral_word_type    w;
      int                  scale;
      int                  d;
      int                  k;
      if (value == '0 || value > MAX_NUMBER) begin
         w.symbol       = SYM_NONE;
         w.last_symbol  = 1'b1;
         w.out_of_range = 1'b1;
         expected_symbols.push_back(w);
         numbers_invalid++;
         return;
      end
      scale = 1000;
      for (int p = 0; p < 4; p++) begin
         d = (int'(value) / scale) % 10;
         if (d == 4) begin
            chars.push_back(place_glyph(p, 0));
            chars.push_back(place_glyph(p, 1));
         end else if (d == 9) begin
            chars.push_back(place_glyph(p, 0));
            chars.push_back(place_glyph(p, 2));
         end else begin
            if (d >= 5) chars.push_back(place_glyph(p, 1));
            for (k = 0; k < d % 5; k++) chars.push_back(place_glyph(p, 0));
         end
         scale = scale / 10;
      end
      for (int i = 0; i < chars.size(); i++) begin
         w.symbol       = chars[i];
         w.last_symbol  = (i == chars.size() - 1);
         w.out_of_range = 1'b0;
         expected_symbols.push_back(w);
      end
      if (chars.size() > longest_numeral) longest_numeral = chars.size();
      numbers_valid++;
   endtask

   // Both sides run without idling for a stretch in the middle of the run.
   always_comb quiet = (cycle_count >= QUIET_FIRST) && (cycle_count < QUIET_LAST);

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_numeral(req_bus.number);
            numbers_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_numbers.size() != 0 &&
                (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_bus.number <= pending_numbers.pop_front();
               req_bus.valid  <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      numeral_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_symbols.size() == 0) begin
               $error("unexpected word: symbol %0d last_symbol %0b out_of_range %0b",
                      rsp_bus.symbol, rsp_bus.last_symbol, rsp_bus.out_of_range);
               error_count++;
            end else begin
               want = expected_symbols.pop_front();
               if (rsp_bus.symbol !== want.symbol) begin
                  $error("symbol: expected %0d, actual %0d", want.symbol, rsp_bus.symbol);
                  error_count++;
               end
               if (rsp_bus.last_symbol !== want.last_symbol) begin
                  $error("last_symbol: expected %0b, actual %0b",
                         want.last_symbol, rsp_bus.last_symbol);
                  error_count++;
               end
               if (rsp_bus.out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0b, actual %0b",
                         want.out_of_range, rsp_bus.out_of_range);
                  error_count++;
               end
               symbols_checked++;
            end
         end
         // One long hold-off lets the block back up all the way to its input.
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && symbols_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("roman_numeral_encoder_core verification failed");
      $finish;
   end

   initial begin
      int pick;
      logic [NUMBER_W-1:0] n;
      // Range edges, every digit pattern, the longest numeral and alternating bits.
      pending_numbers = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd8, 12'd9, 12'd40, 12'd80,
                          12'd90, 12'd400, 12'd800, 12'd900, 12'd1000, 12'd3000,
                          12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2048, 12'd1994,
                          12'd444, 12'd3449, 12'd2730, 12'd1365};
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            n = NUMBER_W'($urandom_range(3999, 1));
         end else if (pick < 88) begin
            n = ($urandom_range(3) == 0) ? '0 : NUMBER_W'($urandom_range(4095, 4000));
         end else begin
            // Digits drawn from the subtractive and longest patterns.
            n = NUMBER_W'($urandom_range(3) * 1000 +
                          ((pick % 3 == 0) ? 4 : (pick % 3 == 1) ? 8 : 9) * 100 +
                          $urandom_range(9) * 10 + ((pick % 2) ? 8 : 9));
            if (n == '0) n = NUMBER_W'(3888);
         end
         pending_numbers.push_back(n);
      end

      @(negedge clock);
      while (pending_numbers.size() != 0 || req_bus.valid || reset) @(negedge clock);
      while (expected_symbols.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_symbols.size() != 0) begin
         $error("%0d expected words never arrived", expected_symbols.size());
         error_count++;
      end

      $display("Converted %0d numbers: %0d in range, %0d rejected as out of range.",
               numbers_sent, numbers_valid, numbers_invalid);
      $display("Compared %0d characters; longest numeral %0d characters, in %0d cycles.",
               symbols_checked, longest_numeral, cycle_count);
      if (error_count == 0) begin
         $display("roman_numeral_encoder_core verification clean");
      end else begin
         $display("roman_numeral_encoder_core verification failed");
      end
      $finish;
   end

endmodule
